// ----- hdl/assert_macros.svh -----
// assertion macros used by the port-level checker file
// each macro expects clk and rst_n in the scope where it is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked while out of reset
`define ILSP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked while out of reset
`define ILSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/ilsp_pkg.sv -----
// shared types, codes and constants of the indexed list slot pool
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ilsp_pkg;

  localparam int POOL_SLOTS_DEF = 64;
  localparam int SLOT_W         = 6;
  localparam int STATUS_W       = 2;

  // shared find-first unit works on one bitmap row at a time
  localparam int FFS_W  = 32;
  localparam int FFS_IW = 5;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL       = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_LISTED = 2'd2;

  typedef struct packed {
    logic              kind;
    logic [SLOT_W-1:0] slot_index;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_out;
    logic                head_valid;
    logic [SLOT_W-1:0]   head_slot;
  } res_t;

  typedef struct packed {
    logic              found;
    logic [FFS_IW-1:0] idx;
  } ffs_res_t;

endpackage

`default_nettype wire

// ----- hdl/ilsp_if.sv -----
// request and result channel interfaces of the slot pool
// depends on ilsp_pkg
`timescale 1ns / 1ps
`default_nettype none

interface ilsp_in_if;
  import ilsp_pkg::*;

  logic              valid;
  logic              ready;
  logic              kind;
  logic [SLOT_W-1:0] slot_index;

  modport source (output valid, kind, slot_index, input ready);
  modport sink (input valid, kind, slot_index, output ready);
endinterface

interface ilsp_out_if;
  import ilsp_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot_out;
  logic                head_valid;
  logic [SLOT_W-1:0]   head_slot;

  modport source (output valid, status, slot_out, head_valid, head_slot, input ready);
  modport sink (input valid, status, slot_out, head_valid, head_slot, output ready);
endinterface

`default_nettype wire

// ----- hdl/ilsp_ffs.sv -----
// shared find-first-set unit over one bitmap word
// depends on ilsp_pkg
`timescale 1ns / 1ps
`default_nettype none

module ilsp_ffs (
  input  wire logic [ilsp_pkg::FFS_W-1:0] vec,
  output ilsp_pkg::ffs_res_t              res
);
  import ilsp_pkg::*;

  always_comb begin
    res.found = |vec;
    res.idx   = '0;
    // scan downward so the lowest set bit wins
    for (int i = FFS_W - 1; i >= 0; i--) begin
      if (vec[i]) begin
        res.idx = FFS_IW'(i);
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/ilsp_core.sv -----
// sequencer, link memories and occupancy bitmap of the slot pool
// depends on ilsp_pkg and ilsp_ffs
`timescale 1ns / 1ps
`default_nettype none

module ilsp_core #(
  parameter int POOL_SLOTS = ilsp_pkg::POOL_SLOTS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  ilsp_pkg::req_t     req,
  output logic               res_vld,
  input  wire logic          res_take,
  output ilsp_pkg::res_t     res
);
  import ilsp_pkg::*;

  localparam int AW        = $clog2(POOL_SLOTS);
  localparam int LW        = AW + 1;
  localparam int ROWS      = (POOL_SLOTS + FFS_W - 1) / FFS_W;
  localparam int RW        = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SW        = RW + FFS_IW;
  localparam int MW        = (AW > SLOT_W) ? AW : SLOT_W;
  localparam int LAST_BITS = POOL_SLOTS - (ROWS - 1) * FFS_W;
  localparam logic [FFS_W-1:0] PAD_MASK = ~((FFS_W'(1) << LAST_BITS) - FFS_W'(1));
  localparam logic [LW-1:0]    NULL_LINK = {1'b1, {AW{1'b0}}};

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_AFIND = 3'd1;
  localparam logic [2:0] S_ASEL  = 3'd2;
  localparam logic [2:0] S_ALINK = 3'd3;
  localparam logic [2:0] S_FCHK  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]          state_r, state_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [SLOT_W-1:0]   slot_out_r, slot_out_nxt;
  logic [AW-1:0]       slot_r, slot_nxt;
  logic [RW-1:0]       row_r, row_nxt;
  logic                head_vld_r, head_vld_nxt;
  logic [AW-1:0]       head_r, head_nxt;
  logic [ROWS-1:0]     row_vld_r, row_vld_nxt;
  logic [ROWS-1:0]     row_full_r, row_full_nxt;

  // bit LW-1 of a link marks null
  logic [LW-1:0]    next_mem [POOL_SLOTS];
  logic [LW-1:0]    prev_mem [POOL_SLOTS];
  logic [FFS_W-1:0] used_mem [ROWS];
  logic [LW-1:0]    nxt_rd_r, prv_rd_r;
  logic [FFS_W-1:0] used_rd_r;

  logic             next_we, prev_we, used_we;
  logic [AW-1:0]    next_wa, prev_wa;
  logic [LW-1:0]    next_wd, prev_wd;
  logic [RW-1:0]    used_wa, used_ra;
  logic [FFS_W-1:0] used_wd;
  logic             used_re;

  logic             acc;
  logic             in_range;
  logic [AW-1:0]    s_in;
  logic [SW-1:0]    s_in_sw, slot_sw, new_sw;
  logic [AW-1:0]    new_slot;
  logic [ROWS-1:0]  not_full;
  logic [FFS_W-1:0] ffs_vec;
  ffs_res_t         ffs_res;
  logic [FFS_W-1:0] sel_row, chk_row, row_pad, bit_mask;
  logic [RW-1:0]    chk_rw;
  logic [FFS_IW-1:0] chk_bit;
  logic             in_use;

  ilsp_ffs u_ffs (
    .vec (ffs_vec),
    .res (ffs_res)
  );

  assign in_ready = (state_r == S_IDLE);
  assign acc      = in_valid && in_ready;
  assign in_range = (32'(req.slot_index) < POOL_SLOTS);
  assign s_in     = AW'(MW'(req.slot_index));
  assign s_in_sw  = SW'(s_in);
  assign slot_sw  = SW'(slot_r);
  assign not_full = ~row_full_r;

  // row and bit of the slot under a free request
  assign chk_rw   = slot_sw[SW-1:FFS_IW];
  assign chk_bit  = slot_sw[FFS_IW-1:0];
  assign chk_row  = row_vld_r[chk_rw] ? used_rd_r : '0;
  assign in_use   = chk_row[chk_bit];

  // row picked for allocate, with unused tail bits shown as taken
  assign row_pad  = (row_r == RW'(ROWS - 1)) ? PAD_MASK : '0;
  assign sel_row  = row_vld_r[row_r] ? used_rd_r : '0;
  assign new_sw   = {row_r, ffs_res.idx};
  assign new_slot = AW'(new_sw);

  always_comb begin
    case (state_r)
      S_AFIND: ffs_vec = FFS_W'(not_full);
      S_ASEL:  ffs_vec = ~(sel_row | row_pad);
      default: ffs_vec = '0;
    endcase
  end

  always_comb begin
    used_re = 1'b0;
    used_ra = s_in_sw[SW-1:FFS_IW];
    if (acc) begin
      used_re = 1'b1;
    end else if (state_r == S_AFIND) begin
      used_re = 1'b1;
      used_ra = RW'(ffs_res.idx);
    end
  end

  always_comb begin
    state_nxt    = state_r;
    status_nxt   = status_r;
    slot_out_nxt = slot_out_r;
    slot_nxt     = slot_r;
    row_nxt      = row_r;
    head_vld_nxt = head_vld_r;
    head_nxt     = head_r;
    row_vld_nxt  = row_vld_r;
    row_full_nxt = row_full_r;
    next_we      = 1'b0;
    next_wa      = slot_r;
    next_wd      = NULL_LINK;
    prev_we      = 1'b0;
    prev_wa      = slot_r;
    prev_wd      = NULL_LINK;
    used_we      = 1'b0;
    used_wa      = row_r;
    used_wd      = '0;
    bit_mask     = '0;

    case (state_r)
      S_IDLE: begin
        if (acc) begin
          slot_out_nxt = req.slot_index;
          slot_nxt     = s_in;
          if (req.kind == KIND_ALLOC) begin
            state_nxt = S_AFIND;
          end else if (!in_range) begin
            status_nxt = ST_NOT_LISTED;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_FCHK;
          end
        end
      end

      S_AFIND: begin
        if (ffs_res.found) begin
          row_nxt   = RW'(ffs_res.idx);
          state_nxt = S_ASEL;
        end else begin
          status_nxt   = ST_FULL;
          slot_out_nxt = '0;
          state_nxt    = S_DONE;
        end
      end

      S_ASEL: begin
        bit_mask              = FFS_W'(1) << ffs_res.idx;
        used_we               = 1'b1;
        used_wa               = row_r;
        used_wd               = sel_row | bit_mask;
        row_vld_nxt[row_r]    = 1'b1;
        row_full_nxt[row_r]   = &(sel_row | bit_mask | row_pad);
        next_we               = 1'b1;
        next_wa               = new_slot;
        next_wd               = head_vld_r ? {1'b0, head_r} : NULL_LINK;
        prev_we               = 1'b1;
        prev_wa               = new_slot;
        prev_wd               = NULL_LINK;
        slot_nxt              = new_slot;
        slot_out_nxt          = SLOT_W'(MW'(new_slot));
        status_nxt            = ST_OK;
        state_nxt             = S_ALINK;
      end

      S_ALINK: begin
        // old head points back at the new one
        prev_we      = head_vld_r;
        prev_wa      = head_r;
        prev_wd      = {1'b0, slot_r};
        head_nxt     = slot_r;
        head_vld_nxt = 1'b1;
        state_nxt    = S_DONE;
      end

      S_FCHK: begin
        if (!in_use) begin
          status_nxt = ST_NOT_LISTED;
        end else begin
          status_nxt           = ST_OK;
          bit_mask             = FFS_W'(1) << chk_bit;
          used_we              = 1'b1;
          used_wa              = chk_rw;
          used_wd              = chk_row & ~bit_mask;
          row_vld_nxt[chk_rw]  = 1'b1;
          row_full_nxt[chk_rw] = 1'b0;
          next_wa              = prv_rd_r[AW-1:0];
          prev_wa              = nxt_rd_r[AW-1:0];
          if (nxt_rd_r[AW] && prv_rd_r[AW]) begin
            head_vld_nxt = 1'b0;
          end else if (nxt_rd_r[AW]) begin
            // tail: predecessor loses its successor
            next_we = 1'b1;
            next_wd = NULL_LINK;
          end else if (prv_rd_r[AW]) begin
            if (head_r == slot_r) begin
              head_nxt = nxt_rd_r[AW-1:0];
            end
            prev_we = 1'b1;
            prev_wd = NULL_LINK;
          end else begin
            next_we = 1'b1;
            next_wd = nxt_rd_r;
            prev_we = 1'b1;
            prev_wd = prv_rd_r;
          end
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res_vld        = (state_r == S_DONE);
  assign res.status     = status_r;
  assign res.slot_out   = slot_out_r;
  assign res.head_valid = head_vld_r;
  assign res.head_slot  = head_vld_r ? SLOT_W'(MW'(head_r)) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      head_vld_r <= 1'b0;
      row_vld_r  <= '0;
      row_full_r <= '0;
    end else begin
      state_r    <= state_nxt;
      head_vld_r <= head_vld_nxt;
      row_vld_r  <= row_vld_nxt;
      row_full_r <= row_full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r   <= status_nxt;
    slot_out_r <= slot_out_nxt;
    slot_r     <= slot_nxt;
    row_r      <= row_nxt;
    head_r     <= head_nxt;
  end

  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    if (acc) begin
      nxt_rd_r <= next_mem[s_in];
    end
  end

  always_ff @(posedge clk) begin
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    if (acc) begin
      prv_rd_r <= prev_mem[s_in];
    end
  end

  always_ff @(posedge clk) begin
    if (used_we) begin
      used_mem[used_wa] <= used_wd;
    end
    if (used_re) begin
      used_rd_r <= used_mem[used_ra];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/indexed_list_slot_pool.sv -----
// allocate: steps through row find, bit select and list link, then the result
// free: an in-use check, then the result; a slot beyond the pool skips the check
// the steps use the registered occupancy bitmap and link memory reads and the shared
// find-first unit; a new request waits until the result moves to the output register
// synchronous active-low reset empties the list; no clearing pass is needed
// top level of the slot pool: channel ports, output register, core
`timescale 1ns / 1ps
`default_nettype none

module indexed_list_slot_pool #(
  parameter int POOL_SLOTS = ilsp_pkg::POOL_SLOTS_DEF
) (
  input wire logic   clk,
  input wire logic   rst_n,
  ilsp_in_if.sink    in_ch,
  ilsp_out_if.source out_ch
);
  import ilsp_pkg::*;

  req_t req;
  res_t core_res;
  res_t out_res_r;
  logic out_valid_r, out_valid_nxt;
  logic core_ready;
  logic core_res_vld;
  logic out_free;

  assign req.kind       = in_ch.kind;
  assign req.slot_index = in_ch.slot_index;
  assign in_ch.ready    = core_ready;

  ilsp_core #(
    .POOL_SLOTS (POOL_SLOTS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (core_ready),
    .req      (req),
    .res_vld  (core_res_vld),
    .res_take (out_free),
    .res      (core_res)
  );

  // output stage is free when it is empty or when the sink takes the held result
  assign out_free      = !out_valid_r || out_ch.ready;
  assign out_valid_nxt = core_res_vld ? 1'b1 : (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (core_res_vld && out_free) begin
      out_res_r <= core_res;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_res_r.status;
  assign out_ch.slot_out   = out_res_r.slot_out;
  assign out_ch.head_valid = out_res_r.head_valid;
  assign out_ch.head_slot  = out_res_r.head_slot;

endmodule

`default_nettype wire

// ----- hdl/ilsp_checker.sv -----
// port-level checker for the slot pool, bound to the top level
// depends on ilsp_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ilsp_port_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [ilsp_pkg::STATUS_W-1:0] out_status,
  input wire logic [ilsp_pkg::SLOT_W-1:0]   out_slot,
  input wire logic                          out_head_valid,
  input wire logic [ilsp_pkg::SLOT_W-1:0]   out_head_slot
);
  import ilsp_pkg::*;

  `ILSP_ASSERT_IMPL(a_status_legal, out_valid, out_status == ST_OK || out_status == ST_FULL || out_status == ST_NOT_LISTED, "illegal status code")
  `ILSP_ASSERT_IMPL(a_empty_head_zero, out_valid && !out_head_valid, out_head_slot == '0, "head slot nonzero on empty list")
  `ILSP_ASSERT_IMPL(a_full_shape, out_valid && out_status == ST_FULL, out_head_valid && out_slot == '0, "pool full with empty list or nonzero slot")
  `ILSP_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "second request taken while one is in flight")
  `ILSP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_slot), "stalled result changed")

endmodule

bind indexed_list_slot_pool ilsp_port_checker u_ilsp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_status     (out_ch.status),
  .out_slot       (out_ch.slot_out),
  .out_head_valid (out_ch.head_valid),
  .out_head_slot  (out_ch.head_slot)
);

`default_nettype wire

// ----- test/ilsp_checker.sv -----
// result checker of the slot pool: tracks the in-use list from accepted requests
// and compares every accepted result with the predicted one
// depends on ilsp_pkg and the channel interfaces in ilsp_if
`timescale 1ns / 1ps
`default_nettype none

module ilsp_checker #(
  parameter int POOL_SLOTS = ilsp_pkg::POOL_SLOTS_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  ilsp_in_if       in_ch,
  ilsp_out_if      out_ch,
  output int       fail_count,
  output int       pending_count
);
  import ilsp_pkg::*;

  localparam int LW = $clog2(POOL_SLOTS + 1);
  // a link equal to the pool size means no neighbor
  localparam logic [LW-1:0] NO_LINK = LW'(POOL_SLOTS);

  logic [LW-1:0] succ_link [POOL_SLOTS];
  logic [LW-1:0] pred_link [POOL_SLOTS];
  logic [LW-1:0] head_link;
  res_t          expected_results [$];

  function automatic bit is_linked(logic [LW-1:0] v);
    return int'(v) < POOL_SLOTS;
  endfunction

  function automatic res_t pack_result(logic [STATUS_W-1:0] st, logic [SLOT_W-1:0] slot);
    res_t r;
    r.status     = st;
    r.slot_out   = slot;
    r.head_valid = is_linked(head_link);
    r.head_slot  = is_linked(head_link) ? SLOT_W'(head_link) : '0;
    return r;
  endfunction

  function automatic res_t take_slot();
    int            pick;
    logic [LW-1:0] slot;
    pick = -1;
    for (int i = 0; i < POOL_SLOTS; i++) begin
      if (pick < 0 && !is_linked(succ_link[i]) && !is_linked(pred_link[i]) &&
          int'(head_link) != i) begin
        pick = i;
      end
    end
    if (pick < 0) begin
      return pack_result(ST_FULL, '0);
    end
    slot = LW'(pick);
    succ_link[pick] = head_link;
    pred_link[pick] = NO_LINK;
    if (is_linked(head_link)) begin
      pred_link[head_link] = slot;
    end
    head_link = slot;
    return pack_result(ST_OK, SLOT_W'(slot));
  endfunction

  function automatic res_t release_slot(logic [SLOT_W-1:0] idx);
    logic [LW-1:0] s;
    logic [LW-1:0] nx;
    logic [LW-1:0] pv;
    if (int'(idx) >= POOL_SLOTS) begin
      return pack_result(ST_NOT_LISTED, idx);
    end
    s  = LW'(idx);
    nx = succ_link[s];
    pv = pred_link[s];
    if (!is_linked(nx) && !is_linked(pv) && head_link != s) begin
      return pack_result(ST_NOT_LISTED, idx);
    end
    if (!is_linked(nx) && !is_linked(pv)) begin
      head_link = NO_LINK;
    end else if (!is_linked(nx)) begin
      succ_link[pv] = NO_LINK;
    end else if (!is_linked(pv)) begin
      if (head_link == s) begin
        head_link = nx;
      end
      pred_link[nx] = NO_LINK;
    end else begin
      succ_link[pv] = nx;
      pred_link[nx] = pv;
    end
    succ_link[s] = NO_LINK;
    pred_link[s] = NO_LINK;
    return pack_result(ST_OK, idx);
  endfunction

  always @(posedge clk) begin
    res_t want;
    res_t got;
    bit   bad;
    if (!rst_n) begin
      for (int i = 0; i < POOL_SLOTS; i++) begin
        succ_link[i] = NO_LINK;
        pred_link[i] = NO_LINK;
      end
      head_link = NO_LINK;
      expected_results.delete();
      fail_count = 0;
    end else begin
      // results first: a request never completes at the edge it is accepted
      if (out_ch.valid && out_ch.ready) begin
        got.status     = out_ch.status;
        got.slot_out   = out_ch.slot_out;
        got.head_valid = out_ch.head_valid;
        got.head_slot  = out_ch.head_slot;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %p", $time, got);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          bad  = 1'b0;
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
            bad = 1'b1;
          end
          if (got.slot_out !== want.slot_out) begin
            $display("%0t: slot_out expected %0d got %0d", $time, want.slot_out,
                     got.slot_out);
            bad = 1'b1;
          end
          if (got.head_valid !== want.head_valid) begin
            $display("%0t: head_valid expected %0d got %0d", $time, want.head_valid,
                     got.head_valid);
            bad = 1'b1;
          end
          if (got.head_slot !== want.head_slot) begin
            $display("%0t: head_slot expected %0d got %0d", $time, want.head_slot,
                     got.head_slot);
            bad = 1'b1;
          end
          if (bad) begin
            fail_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.kind == KIND_ALLOC) begin
          expected_results.push_back(take_slot());
        end else begin
          expected_results.push_back(release_slot(in_ch.slot_index));
        end
      end
    end
    pending_count = expected_results.size();
  end

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// top of the slot pool testbench: clock, reset, request and result stimulus, verdict
// depends on ilsp_pkg, ilsp_if, the block and ilsp_checker
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
  import ilsp_pkg::*;

  localparam int RANDOM_REQS  = 1100;
  localparam int QUIET_TAIL   = 150;
  localparam int HOLD_AT      = 500;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DIRECTED_N   = 15;

  // extremes, every kind and the sole, tail, head, middle and not-listed frees
  localparam req_t DIRECTED [DIRECTED_N] = '{
    '{KIND_ALLOC, 6'd0},  '{KIND_FREE, 6'd0},   '{KIND_FREE, 6'd0},
    '{KIND_FREE, 6'd63},  '{KIND_ALLOC, 6'd63}, '{KIND_ALLOC, 6'd0},
    '{KIND_ALLOC, 6'd21}, '{KIND_ALLOC, 6'd42}, '{KIND_FREE, 6'd0},
    '{KIND_FREE, 6'd3},   '{KIND_ALLOC, 6'd7},  '{KIND_FREE, 6'd2},
    '{KIND_FREE, 6'd1},   '{KIND_FREE, 6'd0},   '{KIND_FREE, 6'd5}
  };

  logic        clk;
  logic        rst_n;
  int          fail_count;
  int          pending_count;
  int          sent_count;
  int unsigned cycle_count;

  ilsp_in_if  in_ch ();
  ilsp_out_if out_ch ();

  indexed_list_slot_pool uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ilsp_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  task automatic send_req(input logic kind, input logic [SLOT_W-1:0] idx);
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= kind;
    in_ch.slot_index <= idx;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent_count++;
  endtask

  task automatic sender_gap(input bit allow);
    if (allow && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // result side: random stall bursts, one long hold-off, always ready at the end
  initial begin
    bit held;
    held = 1'b0;
    forever begin
      if (sent_count >= DIRECTED_N + RANDOM_REQS - QUIET_TAIL) begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end else if (!held && sent_count >= HOLD_AT) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  end

  initial begin
    int remaining;
    int seg_len;
    int alloc_pct;
    bit seg_idle;
    bit first_seg;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.kind       <= KIND_ALLOC;
    in_ch.slot_index <= '0;
    sent_count = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIRECTED_N; i++) begin
      send_req(DIRECTED[i].kind, DIRECTED[i].slot_index);
      sender_gap(1'b1);
    end

    remaining = RANDOM_REQS;
    first_seg = 1'b1;
    while (remaining > 0) begin
      // segments pull the list toward full, toward empty or keep it churning
      case ($urandom_range(0, 3))
        0: alloc_pct = 100;
        1: alloc_pct = 85;
        2: alloc_pct = 50;
        default: alloc_pct = 15;
      endcase
      seg_len  = $urandom_range(30, 120);
      seg_idle = ($urandom_range(0, 3) != 0);
      if (first_seg) begin
        alloc_pct = 100;
        seg_len   = 80;
        first_seg = 1'b0;
      end
      if (seg_len > remaining) begin
        seg_len = remaining;
      end
      for (int j = 0; j < seg_len; j++) begin
        if ($urandom_range(1, 100) <= alloc_pct) begin
          send_req(KIND_ALLOC, SLOT_W'($urandom_range(0, 63)));
        end else begin
          send_req(KIND_FREE, SLOT_W'($urandom_range(0, 63)));
        end
        remaining--;
        sender_gap(seg_idle && remaining > QUIET_TAIL);
      end
    end
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
